### rtl/core/lfct_pkg.sv
// shared types and constants for the lfu cache table
package lfct_pkg;

    localparam int KEY_W  = 32;
    localparam int DATA_W = 32;
    localparam int CFG_W  = 5;

    localparam logic [CFG_W-1:0] CAP_RESET = 5'd16;

    localparam logic MODE_GET = 1'b0;
    localparam logic MODE_PUT = 1'b1;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SWEEP,
        ST_DONE
    } state_t;

    typedef enum logic [1:0] {
        OP_LOOKUP,
        OP_TOUCH,
        OP_EVICT,
        OP_INSERT
    } sweep_op_t;

    typedef struct packed {
        logic match;
        logic better;
        logic free_slot;
        logic wr_en;
    } alu_flags_t;

endpackage

### rtl/core/lfct_entry_ram.sv
// entry storage: one write port, one registered read port
module lfct_entry_ram #(
    parameter int WIDTH     = 88,
    parameter int DEPTH     = 16,
    parameter int ADDR_BITS = 4
) (
    input  logic                 clk,
    input  logic                 we,
    input  logic [ADDR_BITS-1:0] waddr,
    input  logic [WIDTH-1:0]     wdata,
    input  logic                 re,
    input  logic [ADDR_BITS-1:0] raddr,
    output logic [WIDTH-1:0]     rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

### rtl/core/lfct_entry_alu.sv
// shared per-entry unit: key match, victim compare and entry update
module lfct_entry_alu #(
    parameter int COUNT_BITS = 16,
    parameter int RANK_BITS  = 4,
    parameter int IDX_BITS   = 4
) (
    input  lfct_pkg::sweep_op_t          op,
    input  logic                         e_valid,
    input  logic [IDX_BITS-1:0]          e_idx,
    input  logic [lfct_pkg::KEY_W-1:0]   e_key,
    input  logic [lfct_pkg::DATA_W-1:0]  e_data,
    input  logic [COUNT_BITS-1:0]        e_count,
    input  logic [RANK_BITS-1:0]         e_rank,
    input  logic [lfct_pkg::KEY_W-1:0]   req_key,
    input  logic [lfct_pkg::DATA_W-1:0]  req_value,
    input  logic                         req_put,
    input  logic [IDX_BITS-1:0]          sel_slot,
    input  logic [RANK_BITS-1:0]         sel_rank,
    input  logic                         best_found,
    input  logic [COUNT_BITS-1:0]        best_count,
    input  logic [RANK_BITS-1:0]         best_rank,
    output lfct_pkg::alu_flags_t         flags,
    output logic [lfct_pkg::KEY_W-1:0]   new_key,
    output logic [lfct_pkg::DATA_W-1:0]  new_data,
    output logic [COUNT_BITS-1:0]        new_count,
    output logic [RANK_BITS-1:0]         new_rank,
    output logic [RANK_BITS-1:0]         score_rank
);

    import lfct_pkg::*;

    logic                  at_sel;
    logic                  live;
    logic [COUNT_BITS-1:0] count_inc;
    logic [RANK_BITS-1:0]  rank_inc;
    logic [RANK_BITS-1:0]  rank_dec;

    always_comb
    begin
        at_sel     = (e_idx == sel_slot);
        count_inc  = (e_count == {COUNT_BITS{1'b1}}) ? e_count : e_count + COUNT_BITS'(1);
        rank_inc   = e_rank + RANK_BITS'(1);
        rank_dec   = e_rank - RANK_BITS'(1);
        flags      = '0;
        live       = 1'b0;
        new_key    = e_key;
        new_data   = e_data;
        new_count  = e_count;
        new_rank   = e_rank;
        score_rank = e_rank;
        unique case (op)
            OP_LOOKUP:
            begin
                flags.match     = e_valid && (e_key == req_key);
                flags.free_slot = !e_valid;
                live            = e_valid;
            end
            OP_TOUCH:
            begin
                if (e_valid && at_sel)
                begin
                    new_data    = req_put ? req_value : e_data;
                    new_count   = count_inc;
                    new_rank    = '0;
                    flags.wr_en = 1'b1;
                end
                else if (e_valid && (e_rank < sel_rank))
                begin
                    new_rank    = rank_inc;
                    flags.wr_en = 1'b1;
                end
            end
            OP_EVICT:
            begin
                live            = e_valid && !at_sel;
                flags.free_slot = !e_valid || at_sel;
                if (live && (e_rank > sel_rank))
                begin
                    new_rank    = rank_dec;
                    score_rank  = rank_dec;
                    flags.wr_en = 1'b1;
                end
            end
            OP_INSERT:
            begin
                if (at_sel)
                begin
                    new_key     = req_key;
                    new_data    = req_value;
                    new_count   = COUNT_BITS'(1);
                    new_rank    = '0;
                    flags.wr_en = 1'b1;
                end
                else if (e_valid)
                begin
                    new_rank    = rank_inc;
                    flags.wr_en = 1'b1;
                end
            end
            default:
            begin
                live = 1'b0;
            end
        endcase
        flags.better = live && (!best_found || (e_count < best_count) ||
                       ((e_count == best_count) && (score_rank > best_rank)));
    end

endmodule

### rtl/core/lfu_cache_table_core.sv
// top level of the lfu cache table: sequencer, valid bits and result register
//
// usage
//   input channel: in_valid / in_stall with mode, lookup_key, write_value.
//   mode get looks up a key, mode put inserts or updates it.
//   output channel: out_valid / out_stall with hit and read_value, one word
//   per input word, in order.
//   config channel: cfg_valid / cfg_ready with cfg_data, the capacity in use;
//   write it only while the block is idle. cfg_ready is always high.
// sequencing
//   every access with nonzero capacity runs as sweeps over all ENTRIES slots
//   through one shared entry unit and the entry ram.
//   get miss: 1 sweep; hit: 2 sweeps (lookup, touch); put of a new key:
//   2 sweeps plus one per eviction. after the last sweep the block enters
//   the done state and loads the result into the output register once that
//   is free; capacity zero goes straight to done. in_stall is high from
//   accept until the result sits in the output register.
// reset clears all valid bits, occupancy and sets capacity to 16.
// a stalled result holds the output register; the block waits to unload it.
module lfu_cache_table_core #(
    parameter int ENTRIES    = 16,
    parameter int COUNT_BITS = 16
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               in_valid,
    output logic                               in_stall,
    input  logic                               mode,
    input  logic signed [lfct_pkg::KEY_W-1:0]  lookup_key,
    input  logic signed [lfct_pkg::DATA_W-1:0] write_value,
    output logic                               out_valid,
    input  logic                               out_stall,
    output logic                               hit,
    output logic signed [lfct_pkg::DATA_W-1:0] read_value,
    input  logic                               cfg_valid,
    output logic                               cfg_ready,
    input  logic [lfct_pkg::CFG_W-1:0]         cfg_data
);

    import lfct_pkg::*;

    localparam int IDX_BITS  = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
    localparam int OCC_BITS  = $clog2(ENTRIES + 1);
    localparam int RANK_BITS = IDX_BITS;
    localparam int CAP_BITS  = (OCC_BITS > CFG_W) ? OCC_BITS : CFG_W;
    localparam int WORD_BITS = KEY_W + DATA_W + COUNT_BITS + RANK_BITS;

    state_t                state_reg, state_next;
    sweep_op_t             op_reg, op_next;
    logic [CFG_W-1:0]      cap_reg, cap_next;
    logic [OCC_BITS-1:0]   occ_reg, occ_next;
    logic [ENTRIES-1:0]    valid_reg, valid_next;
    logic [OCC_BITS-1:0]   cnt_reg, cnt_next;
    logic                  pipe_vld_reg, pipe_vld_next;
    logic [IDX_BITS-1:0]   pipe_idx_reg, pipe_idx_next;
    logic                  hit_found_reg, hit_found_next;
    logic                  cand_found_reg, cand_found_next;
    logic                  free_found_reg, free_found_next;
    logic                  out_valid_reg, out_valid_next;

    logic                  req_put_reg, req_put_next;
    logic [KEY_W-1:0]      req_key_reg, req_key_next;
    logic [DATA_W-1:0]     req_value_reg, req_value_next;
    logic [IDX_BITS-1:0]   hit_slot_reg, hit_slot_next;
    logic [RANK_BITS-1:0]  hit_rank_reg, hit_rank_next;
    logic [DATA_W-1:0]     hit_data_reg, hit_data_next;
    logic [IDX_BITS-1:0]   cand_slot_reg, cand_slot_next;
    logic [COUNT_BITS-1:0] cand_count_reg, cand_count_next;
    logic [RANK_BITS-1:0]  cand_rank_reg, cand_rank_next;
    logic [IDX_BITS-1:0]   ev_slot_reg, ev_slot_next;
    logic [RANK_BITS-1:0]  ev_rank_reg, ev_rank_next;
    logic [IDX_BITS-1:0]   free_slot_reg, free_slot_next;
    logic                  res_hit_reg, res_hit_next;
    logic [DATA_W-1:0]     res_value_reg, res_value_next;
    logic                  out_hit_reg, out_hit_next;
    logic [DATA_W-1:0]     out_value_reg, out_value_next;

    logic [CAP_BITS-1:0]   cap_ext;
    logic [CAP_BITS-1:0]   cap_eff;
    logic [CAP_BITS-1:0]   occ_ext;
    logic [CAP_BITS-1:0]   occ_dec;
    logic                  evict_now;
    logic                  evict_again;
    logic                  sweep_done;
    logic                  in_accept;
    logic                  out_free;

    logic                  ram_we;
    logic [IDX_BITS-1:0]   ram_waddr;
    logic [WORD_BITS-1:0]  ram_wdata;
    logic                  ram_re;
    logic [IDX_BITS-1:0]   ram_raddr;
    logic [WORD_BITS-1:0]  ram_rdata;

    logic [KEY_W-1:0]      e_key;
    logic [DATA_W-1:0]     e_data;
    logic [COUNT_BITS-1:0] e_count;
    logic [RANK_BITS-1:0]  e_rank;
    logic [IDX_BITS-1:0]   sel_slot;
    logic [RANK_BITS-1:0]  sel_rank;
    alu_flags_t            alu_flags;
    logic [KEY_W-1:0]      new_key;
    logic [DATA_W-1:0]     new_data;
    logic [COUNT_BITS-1:0] new_count;
    logic [RANK_BITS-1:0]  new_rank;
    logic [RANK_BITS-1:0]  score_rank;

    assign e_key   = ram_rdata[WORD_BITS-1 -: KEY_W];
    assign e_data  = ram_rdata[WORD_BITS-KEY_W-1 -: DATA_W];
    assign e_count = ram_rdata[RANK_BITS +: COUNT_BITS];
    assign e_rank  = ram_rdata[RANK_BITS-1:0];

    assign ram_re    = (state_reg == ST_SWEEP) && (cnt_reg < OCC_BITS'(ENTRIES));
    assign ram_raddr = cnt_reg[IDX_BITS-1:0];
    assign ram_we    = pipe_vld_reg && alu_flags.wr_en;
    assign ram_waddr = pipe_idx_reg;
    assign ram_wdata = {new_key, new_data, new_count, new_rank};

    lfct_entry_ram #(
        .WIDTH     (WORD_BITS),
        .DEPTH     (ENTRIES),
        .ADDR_BITS (IDX_BITS)
    ) u_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    always_comb
    begin
        unique case (op_reg)
            OP_TOUCH:
            begin
                sel_slot = hit_slot_reg;
                sel_rank = hit_rank_reg;
            end
            OP_EVICT:
            begin
                sel_slot = ev_slot_reg;
                sel_rank = ev_rank_reg;
            end
            OP_INSERT:
            begin
                sel_slot = free_slot_reg;
                sel_rank = '0;
            end
            default:
            begin
                sel_slot = hit_slot_reg;
                sel_rank = '0;
            end
        endcase
    end

    lfct_entry_alu #(
        .COUNT_BITS (COUNT_BITS),
        .RANK_BITS  (RANK_BITS),
        .IDX_BITS   (IDX_BITS)
    ) u_alu (
        .op         (op_reg),
        .e_valid    (valid_reg[pipe_idx_reg]),
        .e_idx      (pipe_idx_reg),
        .e_key      (e_key),
        .e_data     (e_data),
        .e_count    (e_count),
        .e_rank     (e_rank),
        .req_key    (req_key_reg),
        .req_value  (req_value_reg),
        .req_put    (req_put_reg),
        .sel_slot   (sel_slot),
        .sel_rank   (sel_rank),
        .best_found (cand_found_reg),
        .best_count (cand_count_reg),
        .best_rank  (cand_rank_reg),
        .flags      (alu_flags),
        .new_key    (new_key),
        .new_data   (new_data),
        .new_count  (new_count),
        .new_rank   (new_rank),
        .score_rank (score_rank)
    );

    assign cap_ext     = CAP_BITS'(cap_reg);
    assign cap_eff     = (cap_ext > CAP_BITS'(ENTRIES)) ? CAP_BITS'(ENTRIES) : cap_ext;
    assign occ_ext     = CAP_BITS'(occ_reg);
    assign occ_dec     = occ_ext - CAP_BITS'(1);
    assign evict_now   = (occ_ext >= cap_eff) && (occ_ext != '0);
    assign evict_again = (occ_dec >= cap_eff) && (occ_dec != '0);
    assign sweep_done  = (cnt_reg == OCC_BITS'(ENTRIES)) && !pipe_vld_reg;
    assign in_accept   = in_valid && !in_stall;
    assign out_free    = !out_valid_reg || !out_stall;

    assign in_stall   = (state_reg != ST_IDLE);
    assign cfg_ready  = 1'b1;
    assign out_valid  = out_valid_reg;
    assign hit        = out_hit_reg;
    assign read_value = out_value_reg;

    always_comb
    begin
        state_next      = state_reg;
        op_next         = op_reg;
        cap_next        = cfg_valid ? cfg_data : cap_reg;
        occ_next        = occ_reg;
        valid_next      = valid_reg;
        cnt_next        = cnt_reg;
        pipe_vld_next   = 1'b0;
        pipe_idx_next   = pipe_idx_reg;
        hit_found_next  = hit_found_reg;
        cand_found_next = cand_found_reg;
        free_found_next = free_found_reg;
        out_valid_next  = out_valid_reg && out_stall;
        req_put_next    = req_put_reg;
        req_key_next    = req_key_reg;
        req_value_next  = req_value_reg;
        hit_slot_next   = hit_slot_reg;
        hit_rank_next   = hit_rank_reg;
        hit_data_next   = hit_data_reg;
        cand_slot_next  = cand_slot_reg;
        cand_count_next = cand_count_reg;
        cand_rank_next  = cand_rank_reg;
        ev_slot_next    = ev_slot_reg;
        ev_rank_next    = ev_rank_reg;
        free_slot_next  = free_slot_reg;
        res_hit_next    = res_hit_reg;
        res_value_next  = res_value_reg;
        out_hit_next    = out_hit_reg;
        out_value_next  = out_value_reg;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_accept)
                begin
                    req_put_next   = (mode == MODE_PUT);
                    req_key_next   = lookup_key;
                    req_value_next = write_value;
                    if (cap_eff == '0)
                    begin
                        res_hit_next   = 1'b0;
                        res_value_next = '0;
                        state_next     = ST_DONE;
                    end
                    else
                    begin
                        op_next         = OP_LOOKUP;
                        state_next      = ST_SWEEP;
                        cnt_next        = '0;
                        hit_found_next  = 1'b0;
                        cand_found_next = 1'b0;
                        free_found_next = 1'b0;
                    end
                end
            end
            ST_SWEEP:
            begin
                if (ram_re)
                begin
                    cnt_next      = cnt_reg + OCC_BITS'(1);
                    pipe_vld_next = 1'b1;
                    pipe_idx_next = ram_raddr;
                end
                if (pipe_vld_reg)
                begin
                    if (alu_flags.match && !hit_found_reg)
                    begin
                        hit_found_next = 1'b1;
                        hit_slot_next  = pipe_idx_reg;
                        hit_rank_next  = e_rank;
                        hit_data_next  = e_data;
                    end
                    if (alu_flags.better)
                    begin
                        cand_found_next = 1'b1;
                        cand_slot_next  = pipe_idx_reg;
                        cand_count_next = e_count;
                        cand_rank_next  = score_rank;
                    end
                    if (alu_flags.free_slot && !free_found_reg)
                    begin
                        free_found_next = 1'b1;
                        free_slot_next  = pipe_idx_reg;
                    end
                end
                if (sweep_done)
                begin
                    cnt_next = '0;
                    unique case (op_reg)
                        OP_LOOKUP:
                        begin
                            res_hit_next   = hit_found_reg;
                            res_value_next = (hit_found_reg && !req_put_reg) ? hit_data_reg : '0;
                            if (hit_found_reg)
                            begin
                                op_next = OP_TOUCH;
                            end
                            else if (!req_put_reg)
                            begin
                                state_next = ST_DONE;
                            end
                            else if (evict_now)
                            begin
                                op_next         = OP_EVICT;
                                ev_slot_next    = cand_slot_reg;
                                ev_rank_next    = cand_rank_reg;
                                cand_found_next = 1'b0;
                                free_found_next = 1'b0;
                            end
                            else
                            begin
                                op_next = OP_INSERT;
                            end
                        end
                        OP_EVICT:
                        begin
                            valid_next[ev_slot_reg] = 1'b0;
                            occ_next = occ_reg - OCC_BITS'(1);
                            if (evict_again)
                            begin
                                ev_slot_next    = cand_slot_reg;
                                ev_rank_next    = cand_rank_reg;
                                cand_found_next = 1'b0;
                                free_found_next = 1'b0;
                            end
                            else
                            begin
                                op_next = OP_INSERT;
                            end
                        end
                        OP_INSERT:
                        begin
                            if (free_found_reg)
                            begin
                                valid_next[free_slot_reg] = 1'b1;
                                occ_next = occ_reg + OCC_BITS'(1);
                            end
                            state_next = ST_DONE;
                        end
                        default:
                        begin
                            state_next = ST_DONE;
                        end
                    endcase
                end
            end
            ST_DONE:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    out_hit_next   = res_hit_reg;
                    out_value_next = res_value_reg;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            op_reg         <= OP_LOOKUP;
            cap_reg        <= CAP_RESET;
            occ_reg        <= '0;
            valid_reg      <= '0;
            cnt_reg        <= '0;
            pipe_vld_reg   <= 1'b0;
            hit_found_reg  <= 1'b0;
            cand_found_reg <= 1'b0;
            free_found_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            op_reg         <= op_next;
            cap_reg        <= cap_next;
            occ_reg        <= occ_next;
            valid_reg      <= valid_next;
            cnt_reg        <= cnt_next;
            pipe_vld_reg   <= pipe_vld_next;
            hit_found_reg  <= hit_found_next;
            cand_found_reg <= cand_found_next;
            free_found_reg <= free_found_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        pipe_idx_reg   <= pipe_idx_next;
        req_put_reg    <= req_put_next;
        req_key_reg    <= req_key_next;
        req_value_reg  <= req_value_next;
        hit_slot_reg   <= hit_slot_next;
        hit_rank_reg   <= hit_rank_next;
        hit_data_reg   <= hit_data_next;
        cand_slot_reg  <= cand_slot_next;
        cand_count_reg <= cand_count_next;
        cand_rank_reg  <= cand_rank_next;
        ev_slot_reg    <= ev_slot_next;
        ev_rank_reg    <= ev_rank_next;
        free_slot_reg  <= free_slot_next;
        res_hit_reg    <= res_hit_next;
        res_value_reg  <= res_value_next;
        out_hit_reg    <= out_hit_next;
        out_value_reg  <= out_value_next;
    end

    a_occ_matches_valid: assert property (@(posedge clk) disable iff (!rst_n)
        $countones(valid_reg) == int'(occ_reg))
        else $error("occupancy disagrees with valid bits");

    a_no_rw_collide: assert property (@(posedge clk) disable iff (!rst_n)
        (ram_we && ram_re) |-> (ram_waddr != ram_raddr))
        else $error("entry ram read and write hit the same slot");

    a_out_from_done: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(state_reg == ST_DONE))
        else $error("result word loaded outside done state");

    a_quiet_outside_sweep: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg != ST_SWEEP) |-> (!pipe_vld_reg && !ram_we))
        else $error("entry traffic outside a sweep");

    a_insert_has_slot: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_SWEEP && op_reg == OP_INSERT) |-> free_found_reg)
        else $error("insert sweep without a free slot");

endmodule
